### sv/rtd_pkg.sv
// rtd_pkg: shared types and constants for the 2-D rigid transform pipeline.
// Holds the port word types, the CORDIC arctangent table and the default parameters.
// No dependencies.
package rtd_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int COORD_BITS_DEF   = 32;
    localparam int ATAN_COUNT       = 24;

    // limit CORDIC gain 0.60725293... in Q1.30
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURN [ATAN_COUNT] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // input word
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        rot_angle;
        logic               last_vertex;
    } vertex_t;

    // output word
    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic               last_out;
    } world_t;

    // fields that ride along with the angle through the CORDIC
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               last;
    } carry_t;

    // one CORDIC stage: rotated unit vector (Q1.30), residual angle, half-turn flag
    typedef struct packed {
        carry_t             carry;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        z;
        logic               flip;
    } rot_t;

endpackage

### sv/rtd_cordic.sv
// rtd_cordic: input skid register, angle reduction and one pipeline stage per CORDIC step.
// Produces cos/sin (Q1.30, before half-turn sign fix) with the vertex fields alongside.
// Depends on rtd_pkg.
module rtd_cordic #(
    parameter int CORDIC_STEPS = rtd_pkg::CORDIC_STEPS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            vertex_valid,
    output logic            vertex_ready,
    input  rtd_pkg::vertex_t vertex,
    input  logic            adv,
    output logic            rot_valid,
    output rtd_pkg::rot_t   rot
);
    import rtd_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STEPS;
    localparam int DEPTH = NSTEP + 1;
    localparam int Z_BOUND = 2 * int'(ATAN_TURN[NSTEP-1]) + NSTEP;

    vertex_t          skid_reg;
    logic             skid_vld_reg;
    logic             skid_vld_next;
    vertex_t          src;
    logic             src_valid;
    logic [31:0]      z_in;
    logic             flip_in;
    rot_t             st_reg  [DEPTH];
    rot_t             st_next [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;

    // skid holds one word taken while the pipeline was frozen
    assign vertex_ready = !skid_vld_reg;
    assign src          = skid_vld_reg ? skid_reg : vertex;
    assign src_valid    = skid_vld_reg || vertex_valid;

    always_comb
    begin
        if (adv)
        begin
            skid_vld_next = 1'b0;
        end
        else
        begin
            skid_vld_next = skid_vld_reg || vertex_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!adv && vertex_valid && vertex_ready)
        begin
            skid_reg <= vertex;
        end
    end

    // angles in the second and third quarter turn: rotate by half a turn, negate later
    assign z_in    = {src.rot_angle, 16'h0000};
    assign flip_in = z_in[31] ^ z_in[30];

    always_comb
    begin
        st_next[0].carry.point_x = src.point_x;
        st_next[0].carry.point_y = src.point_y;
        st_next[0].carry.pos_x   = src.pos_x;
        st_next[0].carry.pos_y   = src.pos_y;
        st_next[0].carry.last    = src.last_vertex;
        st_next[0].x             = GAIN_Q30;
        st_next[0].y             = 32'sd0;
        st_next[0].z             = flip_in ? (z_in ^ 32'h8000_0000) : z_in;
        st_next[0].flip          = flip_in;
    end

    for (genvar g = 0; g < NSTEP; g++)
    begin : g_step
        always_comb
        begin
            st_next[g+1] = st_reg[g];
            if (!st_reg[g].z[31])
            begin
                st_next[g+1].x = st_reg[g].x - (st_reg[g].y >>> g);
                st_next[g+1].y = st_reg[g].y + (st_reg[g].x >>> g);
                st_next[g+1].z = st_reg[g].z - ATAN_TURN[g];
            end
            else
            begin
                st_next[g+1].x = st_reg[g].x + (st_reg[g].y >>> g);
                st_next[g+1].y = st_reg[g].y - (st_reg[g].x >>> g);
                st_next[g+1].z = st_reg[g].z + ATAN_TURN[g];
            end
        end
    end

    assign vld_next = {vld_reg[DEPTH-2:0], src_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign rot_valid = vld_reg[DEPTH-1];
    assign rot       = st_reg[DEPTH-1];

`ifndef ASSERT_OFF
    // skid only fills during a frozen cycle
    a_skid_after_stall: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> $past(!adv))
        else $error("skid register full without a preceding stall");

    // residual angle has converged after the last step
    a_residual_small: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DEPTH-1] |-> ($signed(st_reg[DEPTH-1].z) <= Z_BOUND
                           && $signed(st_reg[DEPTH-1].z) >= -Z_BOUND))
        else $error("CORDIC residual angle out of bound");

    // skid cannot hold a word while the pipeline is moving and empty at entry
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_vld_reg && adv) |=> vld_reg[0])
        else $error("skid word lost when pipeline advanced");
`endif

endmodule

### sv/rtd_mac.sv
// rtd_mac: sign fix, four products, rounded sums and translate/saturate output register.
// Four register stages; the last one is the block's output register.
// Depends on rtd_pkg.
module rtd_mac #(
    parameter int COORD_BITS = rtd_pkg::COORD_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           rot_valid,
    input  rtd_pkg::rot_t  rot,
    output logic           world_valid,
    output rtd_pkg::world_t world
);
    import rtd_pkg::*;

    localparam int SAT_W = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam logic signed [35:0] SAT_HI = 36'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
    localparam logic signed [35:0] SAT_LO = -SAT_HI - 36'sd1;
    localparam logic signed [64:0] ROUND_HALF = 65'sd536870912;
    localparam logic signed [31:0] CS_BOUND = 32'sd1073741888;

    typedef struct packed {
        carry_t             carry;
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } trig_t;

    typedef struct packed {
        logic signed [63:0] xc;
        logic signed [63:0] ys;
        logic signed [63:0] xs;
        logic signed [63:0] yc;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               last;
    } prod_t;

    typedef struct packed {
        logic signed [64:0] sx;
        logic signed [64:0] sy;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               last;
    } sum_t;

    trig_t       trig_reg, trig_next;
    prod_t       prod_reg, prod_next;
    sum_t        sum_reg,  sum_next;
    world_t      out_reg,  out_next;
    logic [3:0]  vld_reg,  vld_next;
    logic signed [35:0] tx, ty;

    function automatic logic signed [31:0] sat(input logic signed [35:0] v);
        logic signed [35:0] c;
        if (v > SAT_HI)
        begin
            c = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            c = SAT_LO;
        end
        else
        begin
            c = v;
        end
        return $signed(c[31:0]);
    endfunction

    // undo the half-turn reduction
    always_comb
    begin
        trig_next.carry = rot.carry;
        trig_next.cos_v = rot.flip ? -rot.x : rot.x;
        trig_next.sin_v = rot.flip ? -rot.y : rot.y;
    end

    always_comb
    begin
        prod_next.xc    = 64'(trig_reg.carry.point_x) * 64'(trig_reg.cos_v);
        prod_next.ys    = 64'(trig_reg.carry.point_y) * 64'(trig_reg.sin_v);
        prod_next.xs    = 64'(trig_reg.carry.point_x) * 64'(trig_reg.sin_v);
        prod_next.yc    = 64'(trig_reg.carry.point_y) * 64'(trig_reg.cos_v);
        prod_next.pos_x = trig_reg.carry.pos_x;
        prod_next.pos_y = trig_reg.carry.pos_y;
        prod_next.last  = trig_reg.carry.last;
    end

    // Q16.16 x Q1.30 -> Q.46, round half up before dropping 30 bits
    always_comb
    begin
        sum_next.sx    = 65'(prod_reg.xc) - 65'(prod_reg.ys) + ROUND_HALF;
        sum_next.sy    = 65'(prod_reg.xs) + 65'(prod_reg.yc) + ROUND_HALF;
        sum_next.pos_x = prod_reg.pos_x;
        sum_next.pos_y = prod_reg.pos_y;
        sum_next.last  = prod_reg.last;
    end

    assign tx = 36'($signed(sum_reg.sx[64:30])) + 36'(sum_reg.pos_x);
    assign ty = 36'($signed(sum_reg.sy[64:30])) + 36'(sum_reg.pos_y);

    always_comb
    begin
        out_next.world_x  = sat(tx);
        out_next.world_y  = sat(ty);
        out_next.last_out = sum_reg.last;
    end

    assign vld_next = {vld_reg[2:0], rot_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            trig_reg <= trig_next;
            prod_reg <= prod_next;
            sum_reg  <= sum_next;
            out_reg  <= out_next;
        end
    end

    assign world_valid = vld_reg[3];
    assign world       = out_reg;

`ifndef ASSERT_OFF
    // gain-compensated vector stays near unit length, so the products cannot overflow
    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (trig_reg.cos_v <= CS_BOUND && trig_reg.cos_v >= -CS_BOUND
                     && trig_reg.sin_v <= CS_BOUND && trig_reg.sin_v >= -CS_BOUND))
        else $error("cos/sin magnitude above one");

    // a frozen pipeline keeps its output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(out_reg))
        else $error("output register changed during stall");
`endif

endmodule

### sv/rigid_transform_2d_points_top.sv
// rigid_transform_2d_points_top: rotates a polygon vertex by a binary angle and adds the
// body position, giving the world point in Q16.16 with saturation. Top level.
// Depends on rtd_pkg, rtd_cordic, rtd_mac.
//
//  channel | signals                            | word
//  --------+------------------------------------+------------------------------------
//  vertex  | vertex_valid, vertex_ready, vertex | point_x/y, pos_x/y, rot_angle, last
//  world   | world_valid, world_ready, world    | world_x, world_y, last_out
//
// One word per cycle sustained while world_ready stays high. min(CORDIC_STEPS, 24) + 5
// register stages: input stage, one stage per CORDIC step, then sign fix, multiply,
// round-sum and translate/saturate (the output register). world_valid rises once a
// word has passed through all of these stages.
// All stages advance together whenever the output register is empty or being taken;
// a word arriving during a stall parks in a one-word skid register at the input, and
// vertex_ready stays low while that register holds a word.
// Reset clears only valid bits; data registers are not reset.
module rigid_transform_2d_points_top #(
    parameter int CORDIC_STEPS = rtd_pkg::CORDIC_STEPS_DEF,
    parameter int COORD_BITS   = rtd_pkg::COORD_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vertex_valid,
    output logic             vertex_ready,
    input  rtd_pkg::vertex_t vertex,
    output logic             world_valid,
    input  logic             world_ready,
    output rtd_pkg::world_t  world
);
    import rtd_pkg::*;

    logic adv;        // whole pipeline moves one stage
    logic rot_valid;
    rot_t rot;

    // freeze only when a finished word is waiting and not taken
    assign adv = !world_valid || world_ready;

    rtd_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .vertex       (vertex),
        .adv          (adv),
        .rot_valid    (rot_valid),
        .rot          (rot)
    );

    rtd_mac #(
        .COORD_BITS (COORD_BITS)
    ) u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .rot_valid   (rot_valid),
        .rot         (rot),
        .world_valid (world_valid),
        .world       (world)
    );

`ifndef ASSERT_OFF
    // input back-pressure only arises behind a waiting output word
    a_ready_low_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !vertex_ready |-> world_valid)
        else $error("vertex_ready low with no output word pending");

    // a stalled output stalls the whole pipeline: nothing new reaches the CORDIC exit
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (world_valid && !world_ready) |=> $stable(rot_valid))
        else $error("pipeline moved during output stall");

    // a waiting output word stays offered and unchanged until taken
    a_world_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (world_valid && !world_ready) |=> (world_valid && $stable(world)))
        else $error("world word changed or dropped before it was taken");
`endif

endmodule

### tb/rigid_transform_2d_points_top_tb.sv
// rigid_transform_2d_points_top_tb: self-checking bench for the 2-D rigid transform top.
// Predicts each world word with its own CORDIC and compares it field by field.
// Depends on rtd_pkg and rigid_transform_2d_points_top.
module rigid_transform_2d_points_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rtd_pkg::*;

    // ------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------
    localparam int ROT_STEPS   = 16;
    localparam int COORD_WIDTH = 32;
    localparam int TABLE_LEN   = 24;
    // drain for longer than a word takes to pass through the pipeline
    localparam int DRAIN_CYCLES = ROT_STEPS + 15;
    // longest legal quiet stretch is the long receiver hold, well under this
    localparam int IDLE_LIMIT   = 4000;
    localparam int LONG_HOLD    = 300;

    // results saturate to at most 32 bits
    localparam int SAT_WIDTH = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

    localparam longint GAIN_START = 64'sd652032874;   // 1/K in Q1.30
    localparam longint ROUND_HALF = 64'sd1 << 29;
    localparam longint SAT_HI     = (64'sd1 <<< (SAT_WIDTH - 1)) - 64'sd1;
    localparam longint SAT_LO     = -SAT_HI - 64'sd1;

    localparam int Q_ONE   = 32'sh0001_0000;           // 1.0 in Q16.16
    localparam int MAX_POS = 32'sh7FFF_FFFF;
    localparam int MAX_NEG = 32'sh8000_0000;

    // binary angles of note
    localparam logic [15:0] ANG_ZERO    = 16'h0000;
    localparam logic [15:0] ANG_EIGHTH  = 16'h2000;
    localparam logic [15:0] ANG_QUARTER = 16'h4000;
    localparam logic [15:0] ANG_HALF    = 16'h8000;
    localparam logic [15:0] ANG_THREEQ  = 16'hC000;

    // arctangent of 2^-i in 2^-32 turn units
    localparam logic [31:0] ARCTAN_TURN [TABLE_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // ------------------------------------------------------------------
    // DUT and its stimulus; every input known from time zero
    // ------------------------------------------------------------------
    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    vertex_valid = 1'b0;
    logic    vertex_ready;
    vertex_t vertex       = '0;
    logic    world_valid;
    logic    world_ready  = 1'b0;
    world_t  world;

    rigid_transform_2d_points_top #(
        .CORDIC_STEPS (ROT_STEPS),
        .COORD_BITS   (COORD_WIDTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .vertex       (vertex),
        .world_valid  (world_valid),
        .world_ready  (world_ready),
        .world        (world)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    world_t world_expected [$];     // predicted world words, oldest first
    int     mismatch_count  = 0;
    int     vertices_taken  = 0;
    int     worlds_checked  = 0;
    int     idle_cycles     = 0;

    // knobs the test tasks flip to shape idling on each side
    bit     vertex_gaps_on  = 1'b0;
    bit     world_stalls_on = 1'b0;
    bit     long_hold_req   = 1'b0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint clamp_coord(input longint v);
        if (v > SAT_HI)
            return SAT_HI;
        if (v < SAT_LO)
            return SAT_LO;
        return v;
    endfunction

    // rotate the vertex by its angle, then translate and saturate
    function automatic world_t transform_vertex(input vertex_t v);
        logic [31:0] z;
        logic        flip;
        longint      cx;
        longint      sy;
        longint      nx;
        longint      px;
        longint      py;
        longint      rx;
        longint      ry;
        int          steps;
        world_t      w;

        z     = {v.rot_angle, 16'h0000};
        // second and third quadrant: rotate by half a turn less, negate after
        flip  = (z[31:30] == 2'b01) || (z[31:30] == 2'b10);
        if (flip)
            z = z - 32'h8000_0000;
        cx    = GAIN_START;
        sy    = 0;
        steps = (ROT_STEPS > TABLE_LEN) ? TABLE_LEN : ROT_STEPS;
        for (int i = 0; i < steps; i++)
        begin
            if (!z[31])
            begin
                nx = cx - (sy >>> i);
                sy = sy + (cx >>> i);
                z  = z - ARCTAN_TURN[i];
            end
            else
            begin
                nx = cx + (sy >>> i);
                sy = sy - (cx >>> i);
                z  = z + ARCTAN_TURN[i];
            end
            cx = nx;
        end
        if (flip)
        begin
            cx = -cx;
            sy = -sy;
        end

        px = longint'($signed(v.point_x));
        py = longint'($signed(v.point_y));
        // Q16.16 x Q1.30, round half up back to Q16.16
        rx = (px * cx - py * sy + ROUND_HALF) >>> 30;
        ry = (px * sy + py * cx + ROUND_HALF) >>> 30;
        rx = clamp_coord(rx + longint'($signed(v.pos_x)));
        ry = clamp_coord(ry + longint'($signed(v.pos_y)));

        w.world_x  = rx[31:0];
        w.world_y  = ry[31:0];
        w.last_out = v.last_vertex;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict on vertex accept, check on world accept.
    // Sampled at the edge, so both handshakes see pre-edge values.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        world_t want;
        if (rst_n)
        begin
            if (world_valid && world_ready)
            begin
                worlds_checked++;
                if (world_expected.size() == 0)
                begin
                    $error("world word with nothing expected: x=%0d y=%0d last=%0b",
                           world.world_x, world.world_y, world.last_out);
                    mismatch_count++;
                end
                else
                begin
                    want = world_expected.pop_front();
                    if (world.world_x !== want.world_x)
                    begin
                        $error("world_x: expected %0d, got %0d",
                               want.world_x, world.world_x);
                        mismatch_count++;
                    end
                    if (world.world_y !== want.world_y)
                    begin
                        $error("world_y: expected %0d, got %0d",
                               want.world_y, world.world_y);
                        mismatch_count++;
                    end
                    if (world.last_out !== want.last_out)
                    begin
                        $error("last_out: expected %0b, got %0b",
                               want.last_out, world.last_out);
                        mismatch_count++;
                    end
                end
            end
            if (vertex_valid && vertex_ready)
            begin
                vertices_taken++;
                world_expected = {world_expected, transform_vertex(vertex)};
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long with no word moving on either side
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((vertex_valid && vertex_ready) || (world_valid && world_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: %0d cycles with no word accepted", idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // mostly back to back, often short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Receiver: drives world_ready. Holds off for the LONG_HOLD stretch
    // when asked, otherwise random stalls or always ready.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        int ready_hold;
        int ready_gap;
        if (!rst_n)
        begin
            ready_hold  = 0;
            ready_gap   = 0;
            world_ready <= 1'b0;
        end
        else if (ready_hold > 0)
        begin
            ready_hold--;
            world_ready <= 1'b0;
        end
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            ready_hold    = LONG_HOLD - 1;
            world_ready   <= 1'b0;
        end
        else if (!world_stalls_on)
            world_ready <= 1'b1;
        else if (ready_gap > 0)
        begin
            ready_gap--;
            world_ready <= 1'b0;
        end
        else
        begin
            world_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                ready_gap = pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Sender. Called right after a rising edge. Valid drops only when a
    // gap follows, so it is never lowered and raised in one step.
    // ------------------------------------------------------------------
    task automatic send_vertex(input vertex_t v);
        int gap;
        gap = vertex_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            vertex_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vertex       <= v;
        vertex_valid <= 1'b1;
        do
            @(posedge clk);
        while (!vertex_ready);
    endtask

    function automatic vertex_t make_vertex(input int px, input int py, input int tx,
                                            input int ty, input logic [15:0] ang,
                                            input logic last);
        vertex_t v;
        v.point_x     = px;
        v.point_y     = py;
        v.pos_x       = tx;
        v.pos_y       = ty;
        v.rot_angle   = ang;
        v.last_vertex = last;
        return v;
    endfunction

    // coordinate mix: mostly a game-sized range, some full range, some rails
    function automatic int rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return int'($urandom_range(0, 400 * Q_ONE)) - 200 * Q_ONE;
        if (r < 8)
            return int'($urandom);
        if (r == 8)
            return $urandom_range(0, 1) ? MAX_POS : MAX_NEG;
        return $urandom_range(0, 6) - 3;
    endfunction

    function automatic logic [15:0] rand_angle();
        if ($urandom_range(0, 7) == 0)
            return 16'({2'($urandom_range(0, 3)), 14'h0000} + $urandom_range(0, 2) - 1);
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic vertex_t rand_vertex();
        return make_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                           rand_angle(), 1'($urandom_range(0, 1)));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // quadrant edges, saturation on both rails, rotation-only overflow,
    // rounding of tiny values, alternating bit patterns
    task automatic test_directed_corners();
        vertex_gaps_on  = 1'b0;
        world_stalls_on = 1'b0;
        send_vertex(make_vertex(0, 0, 0, 0, ANG_ZERO, 1'b0));
        send_vertex(make_vertex(Q_ONE, 0, 0, 0, ANG_QUARTER, 1'b0));
        send_vertex(make_vertex(Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 4 * Q_ONE, ANG_HALF, 1'b0));
        send_vertex(make_vertex(Q_ONE, 0, 0, 0, ANG_THREEQ, 1'b1));
        send_vertex(make_vertex(100 * Q_ONE, -50 * Q_ONE, 0, 0, ANG_QUARTER - 16'd1, 1'b0));
        send_vertex(make_vertex(100 * Q_ONE, -50 * Q_ONE, 0, 0, ANG_THREEQ - 16'd1, 1'b0));
        send_vertex(make_vertex(-7 * Q_ONE, 9 * Q_ONE, Q_ONE, -Q_ONE, 16'hFFFF, 1'b1));
        send_vertex(make_vertex(-7 * Q_ONE, 9 * Q_ONE, Q_ONE, -Q_ONE, 16'h0001, 1'b0));
        // translation overflow, both directions
        send_vertex(make_vertex(MAX_POS, MAX_POS, MAX_POS, MAX_POS, ANG_ZERO, 1'b0));
        send_vertex(make_vertex(MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, ANG_ZERO, 1'b1));
        // rotation alone pushes past the range at 45 and 135 degrees
        send_vertex(make_vertex(MAX_POS, MAX_POS, 0, 0, ANG_EIGHTH, 1'b0));
        send_vertex(make_vertex(MAX_NEG, MAX_NEG, 0, 0, ANG_EIGHTH, 1'b0));
        send_vertex(make_vertex(MAX_POS, MAX_NEG, 0, 0, 16'h6000, 1'b1));
        send_vertex(make_vertex(MAX_POS, 0, MAX_NEG, 0, ANG_HALF, 1'b0));
        // rounding on single-lsb coordinates
        send_vertex(make_vertex(1, 1, 0, 0, 16'h1555, 1'b0));
        send_vertex(make_vertex(-1, -1, 0, 0, 16'h2AAA, 1'b0));
        send_vertex(make_vertex(-1, 0, MAX_NEG, MAX_POS, ANG_ZERO, 1'b1));
        send_vertex(make_vertex(0, 0, MAX_POS, MAX_NEG, 16'h9ABC, 1'b0));
        // bit patterns
        send_vertex(make_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 16'hFFFF, 1'b1));
        send_vertex(make_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                                32'hAAAA_AAAA, 16'hAAAA, 1'b0));
        send_vertex(make_vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                32'h5555_5555, 16'h5555, 1'b1));
    endtask

    // polygons of one body: shared pose, last mark on the closing vertex.
    // A few are broken: never closed, or closed on every vertex.
    task automatic test_polygon_stream();
        int          corners;
        int          shape;
        int          tx;
        int          ty;
        logic [15:0] ang;
        logic        mark;
        vertex_gaps_on  = 1'b1;
        world_stalls_on = 1'b1;
        for (int p = 0; p < 60; p++)
        begin
            corners = $urandom_range(3, 8);
            shape   = $urandom_range(0, 19);
            tx      = rand_coord();
            ty      = rand_coord();
            ang     = rand_angle();
            for (int k = 0; k < corners; k++)
            begin
                if (shape == 0)
                    mark = 1'b0;
                else if (shape == 1)
                    mark = 1'b1;
                else
                    mark = (k == corners - 1);
                send_vertex(make_vertex(rand_coord(), rand_coord(), tx, ty, ang, mark));
            end
        end
    endtask

    // unrelated words, every field random
    task automatic test_random_words();
        vertex_gaps_on  = 1'b1;
        world_stalls_on = 1'b1;
        repeat (100)
            send_vertex(rand_vertex());
    endtask

    // receiver holds off for a long stretch while the sender keeps
    // offering words; the pipe and skid fill and vertex_ready must drop
    task automatic test_output_backpressure();
        vertex_gaps_on  = 1'b0;
        world_stalls_on = 1'b1;
        long_hold_req   = 1'b1;
        repeat (60)
            send_vertex(rand_vertex());
    endtask

    // no idling on either side: one word per cycle
    task automatic test_full_rate_stream();
        vertex_gaps_on  = 1'b0;
        world_stalls_on = 1'b0;
        repeat (40)
            send_vertex(rand_vertex());
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_polygon_stream();
        test_random_words();
        test_output_backpressure();
        test_full_rate_stream();

        // stop offering, let the pipe empty, then watch for strays
        vertex_valid <= 1'b0;
        world_stalls_on = 1'b1;
        while (world_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d vertices in, %0d world words checked, %0d mismatches",
                 vertices_taken, worlds_checked, mismatch_count);
        $display("covered quadrant edges, both saturation rails, polygons, random words,");
        $display("a long output hold-off and full-rate streaming");
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
sv/rtd_pkg.sv
sv/rtd_cordic.sv
sv/rtd_mac.sv
sv/rigid_transform_2d_points_top.sv
tb/rigid_transform_2d_points_top_tb.sv
